/* rtl/core/fcu_pkg.sv */
// frame chain unwinder: shared types, codes and constants
`default_nettype none

package fcu_pkg;

    // result kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // stop codes
    localparam logic [2:0] STOP_COMPLETE   = 3'd0;
    localparam logic [2:0] STOP_NO_STACK   = 3'd1;
    localparam logic [2:0] STOP_MISALIGNED = 3'd2;
    localparam logic [2:0] STOP_OUTSIDE    = 3'd3;
    localparam logic [2:0] STOP_ORDER      = 3'd4;
    localparam logic [2:0] STOP_LR_OUTSIDE = 3'd5;
    localparam logic [2:0] STOP_DEPTH      = 3'd6;

    // operations
    localparam logic OP_START  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_STACK_LOW  = 2'd0;
    localparam logic [1:0] REG_STACK_HIGH = 2'd1;
    localparam logic [1:0] REG_CODE_LOW   = 2'd2;
    localparam logic [1:0] REG_CODE_HIGH  = 2'd3;

    // frame record geometry, alignment is a power of two
    localparam int          FRAME_ALIGN   = 16;
    localparam logic [63:0] ALIGN_MASK    = 64'(FRAME_ALIGN - 1);
    localparam logic [63:0] RECORD_BYTES  = 64'd16;
    localparam logic [63:0] SP_BYTES      = 64'd8;

    // one result entry
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic [3:0]  slot;
        logic [2:0]  code;
    } res_t;

    // range [low, high) holds size bytes at addr
    function automatic logic in_stack(input logic [63:0] low, input logic [63:0] high,
                                      input logic [63:0] addr, input logic [63:0] size);
        in_stack = (low < high) && (addr >= low) && (addr <= high) &&
                   (size <= (high - addr));
    endfunction

    // addr lies in [low, high)
    function automatic logic in_text(input logic [63:0] low, input logic [63:0] high,
                                     input logic [63:0] addr);
        in_text = (addr >= low) && (addr < high);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/frame_chain_unwinder.sv */
// frame chain unwinder: validated frame-pointer backtrace walker
//
// The slave channel takes requests: tuser 0 starts a walk from pc, lr, sp and
// fp; tuser 1 delivers the frame record fetched at the last requested address.
// The master channel returns up to three results per request: appended frames,
// a fetch request for the next record, or a stop with a stop code. tlast marks
// the final result of a request. A record request with no fetch outstanding
// gives no result.
// A request is registered in the input stage, then its results in the result buffer.
// Throughput: one request per cycle while each gives at most one result and
// m_tready is high; a request giving several results holds the 3-entry result
// buffer until its last result is taken.
// A stall on the master side fills the result buffer and then the input
// register, after which s_tready drops; nothing is lost.
// Reset clears the walk state and the range registers to zero and empties
// both stages. The user writes range registers through cfg_wen/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module frame_chain_unwinder #(
    parameter int MAX_DEPTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration writes
    input  wire logic         cfg_wen,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: start_pc[63:0], link_value[127:64], stack_pointer[191:128],
    //        frame_value[255:192]
    input  wire logic [255:0] s_tdata,
    // tuser: op
    input  wire logic         s_tuser,
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: value[63:0], frame_slot[67:64], stop_code[70:68], zero[71]
    output logic [71:0]       m_tdata,
    // tuser: kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    import fcu_pkg::*;

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_LIMIT = CW'(MAX_DEPTH);

    // range registers
    logic [63:0] stack_low_reg, stack_high_reg, code_low_reg, code_high_reg;

    // walk state
    logic [CW-1:0] frames_kept_reg, frames_kept_next;
    logic [CW-1:0] records_seen_reg, records_seen_next;
    logic [63:0]   last_frame_reg, last_frame_next;
    logic [63:0]   cur_fp_reg, cur_fp_next;
    logic [63:0]   saved_sp_reg, saved_sp_next;
    logic          awaiting_reg, awaiting_next;

    // input stage
    logic          in_valid_reg;
    logic          in_op_reg;
    logic [63:0]   in_pc_reg, in_link_reg, in_sp_reg, in_fp_reg;

    // result buffer
    res_t          res_reg [3];
    res_t          res_next [3];
    logic [1:0]    cnt_reg, idx_reg;
    logic [1:0]    cnt_next;

    logic          out_done, buf_free, s_fire;
    res_t          head;

    // handshakes
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (idx_reg == (cnt_reg - 2'd1));
    assign out_done = m_tvalid && m_tready && m_tlast;
    assign buf_free = (cnt_reg == 2'd0) || out_done;
    assign s_tready = !in_valid_reg || buf_free;
    assign s_fire   = s_tvalid && s_tready;

    // output packing
    assign head    = res_reg[idx_reg];
    assign m_tdata = {1'b0, head.code, head.slot, head.value};
    assign m_tuser = head.kind;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_low_reg  <= '0;
            stack_high_reg <= '0;
            code_low_reg   <= '0;
            code_high_reg  <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_STACK_LOW:  stack_low_reg  <= cfg_wdata;
                REG_STACK_HIGH: stack_high_reg <= cfg_wdata;
                REG_CODE_LOW:   code_low_reg   <= cfg_wdata;
                REG_CODE_HIGH:  code_high_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (buf_free) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= s_tuser;
            in_pc_reg   <= s_tdata[63:0];
            in_link_reg <= s_tdata[127:64];
            in_sp_reg   <= s_tdata[191:128];
            in_fp_reg   <= s_tdata[255:192];
        end
    end

    // walk step: results and next state for the registered request
    always_comb begin
        logic [1:0]  n;
        logic        do_adv;
        logic        halted;
        logic [63:0] fp;
        logic        pc_add;

        frames_kept_next  = frames_kept_reg;
        records_seen_next = records_seen_reg;
        last_frame_next   = last_frame_reg;
        cur_fp_next       = cur_fp_reg;
        saved_sp_next     = saved_sp_reg;
        awaiting_next     = awaiting_reg;
        for (int i = 0; i < 3; i++) begin
            res_next[i] = '0;
        end
        n      = 2'd0;
        do_adv = 1'b0;
        halted = 1'b0;
        fp     = in_fp_reg;
        pc_add = 1'b0;

        if (in_op_reg == OP_START) begin
            // fresh walk
            frames_kept_next  = '0;
            records_seen_next = '0;
            last_frame_next   = '0;
            cur_fp_next       = '0;
            saved_sp_next     = in_sp_reg;
            awaiting_next     = 1'b0;
            if (!in_stack(stack_low_reg, stack_high_reg, in_sp_reg, SP_BYTES)) begin
                res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0, code: STOP_NO_STACK};
                n = n + 2'd1;
            end else begin
                // pc frame, first slot so never a repeat
                if (in_text(code_low_reg, code_high_reg, in_pc_reg)) begin
                    pc_add = 1'b1;
                    res_next[n] = '{kind: KIND_FRAME, value: in_pc_reg, slot: 4'd0,
                                    code: STOP_COMPLETE};
                    n = n + 2'd1;
                    last_frame_next  = in_pc_reg;
                    frames_kept_next = frames_kept_next + CW'(1);
                end
                // lr frame, dropped when equal to the pc frame
                if (in_text(code_low_reg, code_high_reg, in_link_reg) &&
                    (!pc_add || (in_link_reg != in_pc_reg))) begin
                    res_next[n] = '{kind: KIND_FRAME, value: in_link_reg,
                                    slot: 4'(frames_kept_next), code: STOP_COMPLETE};
                    n = n + 2'd1;
                    last_frame_next  = in_link_reg;
                    frames_kept_next = frames_kept_next + CW'(1);
                end
                do_adv = 1'b1;
            end
        end else if (awaiting_reg) begin
            records_seen_next = records_seen_reg + CW'(1);
            // saved return address
            if (in_link_reg != 64'd0) begin
                if (!in_text(code_low_reg, code_high_reg, in_link_reg)) begin
                    res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0,
                                    code: STOP_LR_OUTSIDE};
                    n = n + 2'd1;
                    awaiting_next = 1'b0;
                    halted = 1'b1;
                end else if ((frames_kept_reg < DEPTH_LIMIT) &&
                             ((frames_kept_reg == '0) || (last_frame_reg != in_link_reg))) begin
                    res_next[n] = '{kind: KIND_FRAME, value: in_link_reg,
                                    slot: 4'(frames_kept_reg), code: STOP_COMPLETE};
                    n = n + 2'd1;
                    last_frame_next  = in_link_reg;
                    frames_kept_next = frames_kept_reg + CW'(1);
                end
            end
            // chain ordering
            if (!halted) begin
                if (in_fp_reg == 64'd0) begin
                    res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0,
                                    code: STOP_COMPLETE};
                    n = n + 2'd1;
                    awaiting_next = 1'b0;
                end else if (in_fp_reg <= cur_fp_reg) begin
                    res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0,
                                    code: STOP_ORDER};
                    n = n + 2'd1;
                    awaiting_next = 1'b0;
                end else begin
                    do_adv = 1'b1;
                end
            end
        end

        // depth and frame pointer checks, then fetch or stop
        if (do_adv) begin
            if ((frames_kept_next >= DEPTH_LIMIT) || (records_seen_next >= DEPTH_LIMIT)) begin
                res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0, code: STOP_DEPTH};
                awaiting_next = 1'b0;
            end else if (fp == 64'd0) begin
                res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0, code: STOP_COMPLETE};
                awaiting_next = 1'b0;
            end else if ((fp & ALIGN_MASK) != 64'd0) begin
                res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0, code: STOP_MISALIGNED};
                awaiting_next = 1'b0;
            end else if ((fp < saved_sp_next) ||
                         !in_stack(stack_low_reg, stack_high_reg, fp, RECORD_BYTES)) begin
                res_next[n] = '{kind: KIND_STOP, value: '0, slot: '0, code: STOP_OUTSIDE};
                awaiting_next = 1'b0;
            end else begin
                res_next[n] = '{kind: KIND_FETCH, value: fp, slot: '0, code: STOP_COMPLETE};
                cur_fp_next   = fp;
                awaiting_next = 1'b1;
            end
            n = n + 2'd1;
        end

        cnt_next = n;
    end

    // walk state update when the request moves into the result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_kept_reg  <= '0;
            records_seen_reg <= '0;
            last_frame_reg   <= '0;
            cur_fp_reg       <= '0;
            saved_sp_reg     <= '0;
            awaiting_reg     <= 1'b0;
        end else if (in_valid_reg && buf_free) begin
            frames_kept_reg  <= frames_kept_next;
            records_seen_reg <= records_seen_next;
            last_frame_reg   <= last_frame_next;
            cur_fp_reg       <= cur_fp_next;
            saved_sp_reg     <= saved_sp_next;
            awaiting_reg     <= awaiting_next;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (in_valid_reg && buf_free) begin
            cnt_reg <= cnt_next;
            idx_reg <= 2'd0;
        end else if (out_done) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // result buffer payload
    always_ff @(posedge aclk) begin
        if (in_valid_reg && buf_free) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // the read index stays inside the filled part of the buffer
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd0) |-> (idx_reg < cnt_reg))
        else $error("result index beyond buffer fill");

    // a fetch request or a stop always closes the results of a request
    a_end_kinds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == KIND_FETCH) || (m_tuser == KIND_STOP))) |-> m_tlast)
        else $error("fetch or stop result not marked last");

    // an outstanding fetch always points at an aligned, non-null record
    a_await_fp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        awaiting_reg |-> ((cur_fp_reg != 64'd0) && ((cur_fp_reg & ALIGN_MASK) == 64'd0)))
        else $error("outstanding fetch with bad frame pointer");

    // depth counters never pass the limit
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (frames_kept_reg <= DEPTH_LIMIT) && (records_seen_reg <= DEPTH_LIMIT))
        else $error("walk depth counter past limit");

    // a stalled result holds its index
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(idx_reg)))
        else $error("result buffer moved under stall");
`endif

endmodule

`default_nettype wire
